/* rtl/msm_pkg.sv */
// shared types and codes for the multi-stack shared memory block
package msm_pkg;

	localparam int SIZE_W = 7;
	localparam int NUM_W  = 5;
	localparam int IDX_W  = 4;
	localparam int DATA_W = 32;
	localparam int CALC_W = 12;

	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_DUMP = 2'd2,
		MODE_RSV  = 2'd3
	} mode_t;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_EMPTY   = 2'd3;

	localparam logic CFG_STACK_SIZE = 1'b0;
	localparam logic CFG_NUM_STACKS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESP,
		ST_DUMP
	} state_t;

endpackage

/* rtl/multi_stack_shared_memory.sv */
// top level: several fixed-size stacks sharing one element memory
//
// input channel: in_valid/in_stall with mode, stack_index, push_value.
// output channel: out_valid/out_stall with status, data_value, last.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 stack_size, 1 num_stacks); write only while the block is idle.
// every input transfer yields one or more results; the final one has last set.
// push, pop and refused requests are accepted, decoded and given their memory
// access in the idle state; the result register loads in the response state.
// a dump walks its elements with one memory read per element, bounded by
// the single read port of the element memory.
// a new item is taken only after the previous item's last result has
// entered the output register; that register holds while out_stall is high,
// and a stall on the output stops the walk of a dump.
// reset clears all fill counts and loads stack_size 64, num_stacks 1;
// the element memory is not cleared, and no clearing pass runs.
module multi_stack_shared_memory import msm_pkg::*; #(
	parameter int MEM_DEPTH  = 64,
	parameter int MAX_STACKS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [SIZE_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic [IDX_W-1:0]         stack_index,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] data_value,
	output logic                     last
);

	logic [SIZE_W-1:0] stack_size_q;
	logic [NUM_W-1:0]  num_stacks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_size_q <= SIZE_W'(64);
			num_stacks_q <= NUM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STACK_SIZE: stack_size_q <= cfg_data;
				CFG_NUM_STACKS: num_stacks_q <= cfg_data[NUM_W-1:0];
				default: ;
			endcase
		end
	end

	msm_ctrl #(
		.MEM_DEPTH  (MEM_DEPTH),
		.MAX_STACKS (MAX_STACKS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.stack_size  (stack_size_q),
		.num_stacks  (num_stacks_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.stack_index (stack_index),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data_value  (data_value),
		.last        (last)
	);

endmodule

/* rtl/msm_mem.sv */
// element memory: one write port, one registered read port
module msm_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [31:0]       wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic signed [31:0]       rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/msm_ctrl.sv */
// operation sequencer: fill counts, memory access and result register
module msm_ctrl import msm_pkg::*; #(
	parameter int MEM_DEPTH  = 64,
	parameter int MAX_STACKS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [SIZE_W-1:0]        stack_size,
	input  logic [NUM_W-1:0]         num_stacks,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic [IDX_W-1:0]         stack_index,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] data_value,
	output logic                     last
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int CW = $clog2(MEM_DEPTH + 1);
	localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;

	state_t state_q, state_d;

	logic [CW-1:0]     counts_q [MAX_STACKS];
	logic [CW-1:0]     cnt;
	logic [CALC_W-1:0] base, push_slot, pop_slot;
	logic              sel_valid, full, empty;
	logic              do_push, do_pop, do_dump;
	logic [1:0]        dec_status;

	logic [1:0]        resp_status_q;
	logic              pop_q;
	logic [CALC_W-1:0] base_q;
	logic [CW-1:0]     n_q, i_q, i_next;
	logic              rd_oob_q;
	logic              dump_last;

	logic              acc, out_free, emit;
	logic              mem_we, mem_re;
	logic [CALC_W-1:0] raddr_full;
	logic signed [DATA_W-1:0] rdata, rd_val;

	logic              out_valid_q, last_q;
	logic [1:0]        status_q;
	logic signed [DATA_W-1:0] data_q;
	logic [1:0]        emit_status;
	logic signed [DATA_W-1:0] emit_data;
	logic              emit_last;

	// request decode
	always_comb begin
		sel_valid = (mode != MODE_RSV)
			&& ({1'b0, stack_index} < num_stacks)
			&& ({1'b0, stack_index} < NUM_W'(MAX_STACKS));
		cnt       = counts_q[stack_index[SW-1:0]];
		base      = CALC_W'(stack_index) * CALC_W'(stack_size);
		push_slot = base + CALC_W'(cnt);
		pop_slot  = push_slot - CALC_W'(1);
		full      = (SIZE_W'(cnt) >= stack_size) || (push_slot >= CALC_W'(MEM_DEPTH));
		empty     = (cnt == '0);
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_dump   = 1'b0;
		dec_status = STAT_OK;
		if (!sel_valid) begin
			dec_status = STAT_INVALID;
		end else if (mode == MODE_PUSH) begin
			if (full) begin
				dec_status = STAT_FULL;
			end else begin
				do_push = 1'b1;
			end
		end else if (empty) begin
			dec_status = STAT_EMPTY;
		end else if (mode == MODE_POP) begin
			do_pop = 1'b1;
		end else begin
			do_dump = 1'b1;
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign i_next    = i_q + CW'(1);
	assign dump_last = (i_next == n_q);
	assign rd_val    = rd_oob_q ? '0 : rdata;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = do_dump ? ST_DUMP : ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DUMP: begin
				if (out_free && dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall    = 1'b1;
		acc         = 1'b0;
		emit        = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		raddr_full  = base;
		emit_status = STAT_OK;
		emit_data   = '0;
		emit_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				acc      = in_valid;
				mem_we   = in_valid && do_push;
				mem_re   = in_valid && (do_pop || do_dump);
				raddr_full = do_pop ? pop_slot : base;
			end
			ST_RESP: begin
				emit        = out_free;
				emit_status = resp_status_q;
				emit_data   = pop_q ? rd_val : '0;
			end
			ST_DUMP: begin
				emit       = out_free;
				emit_data  = rd_val;
				emit_last  = dump_last;
				mem_re     = out_free && !dump_last;
				raddr_full = base_q + CALC_W'(i_next);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_STACKS; k++) begin
				counts_q[k] <= '0;
			end
		end else if (acc && do_push) begin
			counts_q[stack_index[SW-1:0]] <= cnt + CW'(1);
		end else if (acc && do_pop) begin
			counts_q[stack_index[SW-1:0]] <= cnt - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			resp_status_q <= dec_status;
			pop_q         <= do_pop;
			base_q        <= base;
			n_q           <= cnt;
		end
		if (acc) begin
			i_q <= '0;
		end else if (state_q == ST_DUMP && emit) begin
			i_q <= i_next;
		end
		if (mem_re) begin
			rd_oob_q <= (raddr_full >= CALC_W'(MEM_DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			data_q   <= emit_data;
			last_q   <= emit_last;
		end
	end

	msm_mem #(
		.DEPTH (MEM_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (push_slot[AW-1:0]),
		.wdata (push_value),
		.re    (mem_re),
		.raddr (raddr_full[AW-1:0]),
		.rdata (rdata)
	);

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign data_value = data_q;
	assign last       = last_q;

endmodule

/* rtl/msm_chk.sv */
// port-level checks for the multi-stack shared memory block
module msm_chk import msm_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [1:0]               status,
	input logic signed [DATA_W-1:0] data_value,
	input logic                     last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(data_value) && $stable(last))
		else $error("stalled result changed");

	// a refused or empty request returns a single zero result
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> last && data_value == '0)
		else $error("error result not final or not zero");

	// one item at a time: no transfer in the cycle after an input transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in back-to-back cycles");

endmodule

bind multi_stack_shared_memory msm_chk u_msm_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.data_value (data_value),
	.last       (last)
);

/* bench/multi_stack_shared_memory_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the multi-stack shared memory: queued transfers, live prediction
module multi_stack_shared_memory_tb;
	import msm_pkg::*;

	localparam int DEPTH       = 64;
	localparam int STACKS      = 16;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		mode_t             op;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
	} stack_op_t;

	typedef struct packed {
		logic [1:0]        stat;
		logic [DATA_W-1:0] data;
		logic              last;
	} stack_result_t;

	typedef struct packed {
		logic [DEPTH-1:0][DATA_W-1:0]  mem;
		logic [DEPTH-1:0]              written;
		logic [STACKS-1:0][SIZE_W-1:0] cnt;
		logic [SIZE_W-1:0]             size;
		logic [NUM_W-1:0]              nstk;
	} stack_state_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic                     cfg_index = 1'b0;
	logic [SIZE_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               mode = '0;
	logic [IDX_W-1:0]         stack_index = '0;
	logic signed [DATA_W-1:0] push_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] data_value;
	logic                     last;

	stack_state_t  live_stacks;
	stack_state_t  planned_stacks;
	stack_result_t op_results [DEPTH];
	bit            op_read_unwritten;
	stack_op_t     queued_ops [$];
	stack_result_t due_results [$];
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	int            mismatches = 0;
	int            quiet_cycles = 0;

	multi_stack_shared_memory #(
		.MEM_DEPTH (DEPTH),
		.MAX_STACKS(STACKS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.stack_index(stack_index),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.data_value (data_value),
		.last       (last)
	);

	always #5 clk = ~clk;

	function automatic logic [DATA_W-1:0] read_slot(input stack_state_t s, input int a);
		if (a >= DEPTH) return '0;
		if (!s.written[a]) op_read_unwritten = 1'b1;
		return s.mem[a];
	endfunction

	function automatic int apply_stack_op(inout stack_state_t s, input stack_op_t o);
		int base;
		int cnt;
		int n;
		op_read_unwritten = 1'b0;
		if (o.op == MODE_RSV || o.idx >= s.nstk) begin
			op_results[0] = '{stat: STAT_INVALID, data: '0, last: 1'b1};
			return 1;
		end
		base = int'(o.idx) * int'(s.size);
		cnt = int'(s.cnt[o.idx]);
		if (o.op == MODE_PUSH) begin
			if (cnt >= int'(s.size) || base + cnt >= DEPTH) begin
				op_results[0] = '{stat: STAT_FULL, data: '0, last: 1'b1};
				return 1;
			end
			s.mem[base + cnt] = o.val;
			s.written[base + cnt] = 1'b1;
			s.cnt[o.idx] = SIZE_W'(cnt + 1);
			op_results[0] = '{stat: STAT_OK, data: '0, last: 1'b1};
			return 1;
		end
		if (cnt == 0) begin
			op_results[0] = '{stat: STAT_EMPTY, data: '0, last: 1'b1};
			return 1;
		end
		if (o.op == MODE_POP) begin
			op_results[0] = '{stat: STAT_OK, data: read_slot(s, base + cnt - 1), last: 1'b1};
			s.cnt[o.idx] = SIZE_W'(cnt - 1);
			return 1;
		end
		n = (cnt > DEPTH) ? DEPTH : cnt;
		for (int i = 0; i < n; i++)
			op_results[i] = '{stat: STAT_OK, data: read_slot(s, base + i), last: (i == n - 1)};
		return n;
	endfunction

	// ops that would read a never-written slot are dropped
	function automatic bit plan_op(input stack_op_t o);
		stack_state_t trial;
		trial = planned_stacks;
		void'(apply_stack_op(trial, o));
		if (op_read_unwritten) return 1'b0;
		planned_stacks = trial;
		queued_ops.push_back(o);
		return 1'b1;
	endfunction

	function automatic void queue_op(input mode_t op, input int idx, input logic [DATA_W-1:0] v);
		void'(plan_op('{op: op, idx: IDX_W'(idx), val: v}));
	endfunction

	function automatic logic [DATA_W-1:0] random_value();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic stack_op_t random_op();
		stack_op_t o;
		int r;
		int live;
		live = (planned_stacks.nstk > STACKS) ? STACKS : int'(planned_stacks.nstk);
		r = $urandom_range(99);
		if (r < 45) o.op = MODE_PUSH;
		else if (r < 74) o.op = MODE_POP;
		else if (r < 92) o.op = MODE_DUMP;
		else o.op = MODE_RSV;
		if ($urandom_range(9) == 0) o.idx = IDX_W'($urandom_range(STACKS - 1));
		else o.idx = IDX_W'($urandom_range(live - 1));
		o.val = random_value();
		return o;
	endfunction

	function automatic void queue_random(input int count);
		repeat (count) begin
			while (!plan_op(random_op())) begin
			end
		end
	endfunction

	task automatic note_error(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (queued_ops.size() != 0 || in_valid || due_results.size() != 0);
	endtask

	task automatic set_idle(input int kind);
		case (kind)
			1: begin send_idle_pct = 51; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 51; end
			3: begin send_idle_pct = 12; stall_pct = 12; end
			default: begin send_idle_pct = 0; stall_pct = 0; end
		endcase
	endtask

	task automatic next_phase(input int size, input int nstk, input int idle_kind);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STACK_SIZE;
		cfg_data <= SIZE_W'(size);
		live_stacks.size = SIZE_W'(size);
		@(posedge clk);
		cfg_index <= CFG_NUM_STACKS;
		cfg_data <= SIZE_W'(nstk);
		live_stacks.nstk = NUM_W'(nstk);
		@(posedge clk);
		cfg_we <= 1'b0;
		planned_stacks.size = SIZE_W'(size);
		planned_stacks.nstk = NUM_W'(nstk);
		set_idle(idle_kind);
		@(negedge clk);
	endtask

	// input side: predict on each transfer, then offer the next queued op
	always @(posedge clk or negedge arst_n) begin
		stack_op_t o;
		int n;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				o = '{op: mode_t'(mode), idx: stack_index, val: push_value};
				n = apply_stack_op(live_stacks, o);
				for (int i = 0; i < n; i++) due_results.push_back(op_results[i]);
			end
			if (!in_valid || !in_stall) begin
				if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					o = queued_ops.pop_front();
					in_valid <= 1'b1;
					mode <= o.op;
					stack_index <= o.idx;
					push_value <= o.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check each transfer against the oldest due result
	always @(posedge clk or negedge arst_n) begin
		stack_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					note_error($sformatf("unexpected result: status %0d data %h last %0d",
						status, data_value, last));
				end else begin
					want = due_results.pop_front();
					if (status !== want.stat || data_value !== want.data || last !== want.last)
						note_error($sformatf(
							"mismatch: status %0d/%0d data %h/%h last %0d/%0d (exp/got)",
							want.stat, status, want.data, data_value, want.last, last));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("multi_stack_shared_memory_tb: errors");
			$finish;
		end
	end

	initial begin
		live_stacks = '0;
		live_stacks.size = SIZE_W'(64);
		live_stacks.nstk = NUM_W'(1);
		planned_stacks = live_stacks;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: empty stack, invalid requests, extreme values
		set_idle(0);
		queue_op(MODE_POP, 0, random_value());
		queue_op(MODE_DUMP, 0, random_value());
		queue_op(MODE_PUSH, 1, random_value());
		queue_op(MODE_POP, 15, random_value());
		queue_op(MODE_RSV, 0, random_value());
		queue_op(MODE_PUSH, 0, 32'h7fff_ffff);
		queue_op(MODE_PUSH, 0, 32'h8000_0000);
		queue_op(MODE_PUSH, 0, 32'hffff_ffff);
		queue_op(MODE_PUSH, 0, 32'h0);
		queue_op(MODE_PUSH, 0, 32'h5555_5555);
		queue_op(MODE_PUSH, 0, 32'haaaa_aaaa);
		queue_op(MODE_POP, 0, random_value());
		queue_op(MODE_DUMP, 0, random_value());
		queue_random(5);

		// one-entry stacks: capacity refusal
		next_phase(1, 16, 1);
		queue_op(MODE_PUSH, 0, random_value());
		queue_op(MODE_PUSH, 15, random_value());
		queue_op(MODE_PUSH, 15, random_value());
		queue_op(MODE_POP, 15, random_value());
		queue_op(MODE_POP, 15, random_value());
		queue_op(MODE_DUMP, 15, random_value());
		queue_op(MODE_DUMP, 0, random_value());
		queue_random(6);

		// top stack fills the end of memory
		next_phase(4, 16, 2);
		repeat (5) queue_op(MODE_PUSH, 15, random_value());
		queue_op(MODE_DUMP, 15, random_value());
		queue_random(6);

		// slices beyond memory: refused push, reads of zero
		next_phase(64, 16, 3);
		queue_op(MODE_PUSH, 1, random_value());
		queue_op(MODE_POP, 15, random_value());
		queue_op(MODE_DUMP, 15, random_value());
		queue_op(MODE_DUMP, 0, random_value());
		queue_random(6);

		next_phase(2, 16, 0);
		queue_op(MODE_PUSH, 3, random_value());
		queue_op(MODE_POP, 3, random_value());
		queue_random(5);

		// one full-memory stack and a dump of every entry
		next_phase(64, 1, 1);
		while (planned_stacks.cnt[0] < 64) queue_op(MODE_PUSH, 0, random_value());
		queue_op(MODE_DUMP, 0, random_value());
		queue_op(MODE_PUSH, 0, random_value());
		queue_random(5);

		next_phase(16, 4, 2);
		queue_random(5);
		wait_drained();
		queue_random(5);

		next_phase(8, 8, 3);
		queue_random(6);

		next_phase(1, 1, 0);
		queue_random(5);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("multi_stack_shared_memory_tb: clean");
		end else begin
			$display("multi_stack_shared_memory_tb: errors");
		end
		$finish;
	end

endmodule
